// File: rtl/timestamp_to_calendar_core_defines.svh
// ----------------------------------------------------------------------------
// Timestamp to calendar core: assertion macros
// Shared assertion helpers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef TIMESTAMP_TO_CALENDAR_CORE_DEFINES_SVH
`define TIMESTAMP_TO_CALENDAR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define TTC_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that an antecedent implies a consequent in the same cycle.
`define TTC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define TTC_ASSERT_ALWAYS(lbl, cond, msg)
`define TTC_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// File: rtl/ttc_pkg.sv
// ----------------------------------------------------------------------------
// Timestamp to calendar package
// Field widths, reciprocal constants and the month start table.
// ----------------------------------------------------------------------------
package ttc_pkg;

    // Field widths
    localparam int TS_W     = 31;
    localparam int YEAR_W   = 11;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int SECOND_W = 6;

    // Internal widths
    localparam int DAYS_W = 15;   // whole days, up to 24855
    localparam int SOD_W  = 17;   // second of day, below 86400
    localparam int QUAD_W = 5;    // four-year cycles, up to 17
    localparam int DOQ_W  = 11;   // day within cycle, below 1461
    localparam int SOH_W  = 12;   // second within hour, below 3600
    localparam int DOY_W  = 9;    // day of year, below 366

    // Calendar constants
    localparam logic [YEAR_W-1:0] EPOCH_YEAR   = 11'd1970;
    localparam logic [16:0]       SECS_PER_DAY = 17'd86400;
    localparam logic [11:0]       SECS_PER_HR  = 12'd3600;
    localparam logic [5:0]        SECS_PER_MIN = 6'd60;
    localparam logic [10:0]       DAYS_PER_QUAD = 11'd1461;

    // Day offsets of the years in a cycle that starts at 1970 (third year leap)
    localparam logic [DOQ_W-1:0] YR1_START = 11'd365;
    localparam logic [DOQ_W-1:0] YR2_START = 11'd730;
    localparam logic [DOQ_W-1:0] YR3_START = 11'd1096;

    // Reciprocals: q = (x * RECIP) >> SHIFT, exact over each operand range
    localparam logic [24:0] DAY_RECIP  = 25'd25451659;  // 1/675 on t >> 7
    localparam int          DAY_SHIFT  = 34;
    localparam logic [14:0] QUAD_RECIP = 15'd22967;     // 1/1461
    localparam int          QUAD_SHIFT = 25;
    localparam logic [16:0] HOUR_RECIP = 17'd74566;     // 1/3600
    localparam int          HOUR_SHIFT = 28;
    localparam logic [12:0] MIN_RECIP  = 13'd4370;      // 1/60
    localparam int          MIN_SHIFT  = 18;

    // First day of year of each month in a common year, index 1 is January
    localparam logic [DOY_W-1:0] MONTH_START [1:12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    // First day of year of a month, shifted by one from March on in a leap year
    function automatic logic [DOY_W-1:0] month_start(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DOY_W-1:0] base;
        base = 9'd0;
        if (m >= 4'd1 && m <= 4'd12)
        begin
            base = MONTH_START[m];
        end
        if (leap && m >= 4'd3)
        begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

// File: rtl/ttc_month_find.sv
// ----------------------------------------------------------------------------
// Timestamp to calendar month finder
// Map a day of year to month and day of month by parallel compares.
// ----------------------------------------------------------------------------
module ttc_month_find
    import ttc_pkg::*;
(
    input  logic [DOY_W-1:0]   doy,
    input  logic               leap,
    output logic [MONTH_W-1:0] month,
    output logic [DAY_W-1:0]   day
);

    logic [MONTH_W-1:0] count;
    logic [DOY_W-1:0]   start;
    logic [DOY_W-1:0]   day_full;

    // Count the month boundaries already passed
    always_comb
    begin
        count = '0;
        for (int m = 2; m <= 12; m++)
        begin
            if (doy >= month_start(MONTH_W'(m), leap))
            begin
                count = count + 4'd1;
            end
        end
        month    = count + 4'd1;
        start    = month_start(month, leap);
        day_full = doy - start + 9'd1;
        day      = day_full[DAY_W-1:0];
    end

endmodule

// File: rtl/timestamp_to_calendar_core.sv
// ----------------------------------------------------------------------------
// Timestamp to calendar core
// Six-stage pipeline converting epoch seconds to year, month, day and time.
// ----------------------------------------------------------------------------
// Each input word carries a 31-bit count of seconds since 1970-01-01 00:00:00
// and yields one output word with year, month, day, hour, minute and second
// (every year divisible by four is leap, exact for 1970 to 2038). A word
// moves stage by stage to the output register; one word may enter per
// cycle unless an output stall backs up the pipe. Every stage has its own
// valid bit and loads whenever it is empty or the stage after it moves, so
// bubbles close up and a stall on the output holds the pipe without loss.
// The depth is set by the chain of reciprocal multiplies: seconds to days,
// days to four-year cycles and the second of day to hours, then minutes,
// each with its multiply in one stage and the back-multiply and subtract in
// the next. Nothing is kept between words and the block has no configuration.
// ----------------------------------------------------------------------------
`include "timestamp_to_calendar_core_defines.svh"

module timestamp_to_calendar_core
    import ttc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [30:0] seconds_since_epoch, [31] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [10:0] cal_year, [14:11] cal_month,
                                        // [19:15] cal_day, [24:20] cal_hour,
                                        // [30:25] cal_minute, [36:31] cal_second,
                                        // [39:37] zero
);

    localparam int STAGES = 6;

    // Stage valid bits and load enables; en[STAGES+1] is the output sink
    logic [STAGES:1]   vld_reg;
    logic [STAGES+1:1] en;

    always_comb
    begin
        en[STAGES+1] = m_axis_tready;
        for (int k = STAGES; k >= 1; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_axis_tready = en[1];
    assign m_axis_tvalid = vld_reg[STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[1])
            begin
                vld_reg[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= STAGES; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: multiply t >> 7 by the reciprocal of 675 (86400 = 675 * 128)
    // ------------------------------------------------------------------
    logic [TS_W-1:0] s1_ts_reg;
    logic [48:0]     s1_pday_reg;
    logic [48:0]     s1_pday_next;

    assign s1_pday_next = {25'd0, s_axis_tdata[TS_W-1:7]} * {24'd0, DAY_RECIP};

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_ts_reg   <= s_axis_tdata[TS_W-1:0];
            s1_pday_reg <= s1_pday_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: take whole days, subtract them back for the second of day
    // ------------------------------------------------------------------
    logic [DAYS_W-1:0] s2_days_reg;
    logic [SOD_W-1:0]  s2_sod_reg;
    logic [DAYS_W-1:0] s2_days_next;
    logic [TS_W-1:0]   s2_dsec;
    logic [TS_W-1:0]   s2_sod_full;

    assign s2_days_next = s1_pday_reg[DAY_SHIFT+DAYS_W-1:DAY_SHIFT];
    assign s2_dsec      = TS_W'({16'd0, s2_days_next} * {14'd0, SECS_PER_DAY});
    assign s2_sod_full  = s1_ts_reg - s2_dsec;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_days_reg <= s2_days_next;
            s2_sod_reg  <= s2_sod_full[SOD_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: reciprocal multiplies for four-year cycles and hours
    // ------------------------------------------------------------------
    logic [DAYS_W-1:0] s3_days_reg;
    logic [SOD_W-1:0]  s3_sod_reg;
    logic [29:0]       s3_pquad_reg;
    logic [33:0]       s3_phour_reg;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_days_reg  <= s2_days_reg;
            s3_sod_reg   <= s2_sod_reg;
            s3_pquad_reg <= {15'd0, s2_days_reg} * {15'd0, QUAD_RECIP};
            s3_phour_reg <= {17'd0, s2_sod_reg} * {17'd0, HOUR_RECIP};
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: day within cycle and second within hour
    // ------------------------------------------------------------------
    logic [QUAD_W-1:0] s4_quad_reg;
    logic [DOQ_W-1:0]  s4_doq_reg;
    logic [HOUR_W-1:0] s4_hour_reg;
    logic [SOH_W-1:0]  s4_soh_reg;
    logic [QUAD_W-1:0] s4_quad_next;
    logic [HOUR_W-1:0] s4_hour_next;
    logic [DAYS_W-1:0] s4_qdays;
    logic [DAYS_W-1:0] s4_doq_full;
    logic [SOD_W-1:0]  s4_hsec;
    logic [SOD_W-1:0]  s4_soh_full;

    assign s4_quad_next = s3_pquad_reg[QUAD_SHIFT+QUAD_W-1:QUAD_SHIFT];
    assign s4_hour_next = s3_phour_reg[HOUR_SHIFT+HOUR_W-1:HOUR_SHIFT];
    assign s4_qdays     = DAYS_W'({10'd0, s4_quad_next} * {4'd0, DAYS_PER_QUAD});
    assign s4_doq_full  = s3_days_reg - s4_qdays;
    assign s4_hsec      = SOD_W'({12'd0, s4_hour_next} * {5'd0, SECS_PER_HR});
    assign s4_soh_full  = s3_sod_reg - s4_hsec;

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_quad_reg <= s4_quad_next;
            s4_doq_reg  <= s4_doq_full[DOQ_W-1:0];
            s4_hour_reg <= s4_hour_next;
            s4_soh_reg  <= s4_soh_full[SOH_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: year within cycle, day of year, minute multiply
    // ------------------------------------------------------------------
    logic [YEAR_W-1:0] s5_year_reg;
    logic [DOY_W-1:0]  s5_doy_reg;
    logic              s5_leap_reg;
    logic [HOUR_W-1:0] s5_hour_reg;
    logic [SOH_W-1:0]  s5_soh_reg;
    logic [24:0]       s5_pmin_reg;
    logic [1:0]        s5_yiq;
    logic [DOQ_W-1:0]  s5_ystart;
    logic [DOQ_W-1:0]  s5_doy_full;

    always_comb
    begin
        if (s4_doq_reg >= YR3_START)
        begin
            s5_yiq    = 2'd3;
            s5_ystart = YR3_START;
        end
        else if (s4_doq_reg >= YR2_START)
        begin
            s5_yiq    = 2'd2;
            s5_ystart = YR2_START;
        end
        else if (s4_doq_reg >= YR1_START)
        begin
            s5_yiq    = 2'd1;
            s5_ystart = YR1_START;
        end
        else
        begin
            s5_yiq    = 2'd0;
            s5_ystart = '0;
        end
        s5_doy_full = s4_doq_reg - s5_ystart;
    end

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_year_reg <= EPOCH_YEAR + {4'd0, s4_quad_reg, 2'b00} + {9'd0, s5_yiq};
            s5_doy_reg  <= s5_doy_full[DOY_W-1:0];
            s5_leap_reg <= (s5_yiq == 2'd2);
            s5_hour_reg <= s4_hour_reg;
            s5_soh_reg  <= s4_soh_reg;
            s5_pmin_reg <= {13'd0, s4_soh_reg} * {12'd0, MIN_RECIP};
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: month and day of month, minute and second; output register
    // ------------------------------------------------------------------
    logic [YEAR_W-1:0]   s6_year_reg;
    logic [MONTH_W-1:0]  s6_month_reg;
    logic [DAY_W-1:0]    s6_day_reg;
    logic [HOUR_W-1:0]   s6_hour_reg;
    logic [MINUTE_W-1:0] s6_minute_reg;
    logic [SECOND_W-1:0] s6_second_reg;
    logic [MONTH_W-1:0]  s6_month_next;
    logic [DAY_W-1:0]    s6_day_next;
    logic [MINUTE_W-1:0] s6_minute_next;
    logic [SOH_W-1:0]    s6_msec;
    logic [SOH_W-1:0]    s6_sec_full;

    ttc_month_find u_month_find
    (
        .doy   (s5_doy_reg),
        .leap  (s5_leap_reg),
        .month (s6_month_next),
        .day   (s6_day_next)
    );

    assign s6_minute_next = s5_pmin_reg[MIN_SHIFT+MINUTE_W-1:MIN_SHIFT];
    assign s6_msec        = SOH_W'({6'd0, s6_minute_next} * {6'd0, SECS_PER_MIN});
    assign s6_sec_full    = s5_soh_reg - s6_msec;

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_year_reg   <= s5_year_reg;
            s6_month_reg  <= s6_month_next;
            s6_day_reg    <= s6_day_next;
            s6_hour_reg   <= s5_hour_reg;
            s6_minute_reg <= s6_minute_next;
            s6_second_reg <= s6_sec_full[SECOND_W-1:0];
        end
    end

    assign m_axis_tdata = {3'd0, s6_second_reg, s6_minute_reg, s6_hour_reg,
                           s6_day_reg, s6_month_reg, s6_year_reg};

    // ------------------------------------------------------------------
    // Checks on the divider stages and the result word
    // ------------------------------------------------------------------
    `TTC_ASSERT_IMPL(a_sod_range, vld_reg[2], s2_sod_reg < SECS_PER_DAY, "second of day out of range")
    `TTC_ASSERT_IMPL(a_rem_range, vld_reg[4], (s4_doq_reg < DAYS_PER_QUAD) && (s4_soh_reg < SECS_PER_HR), "cycle or hour remainder out of range")
    `TTC_ASSERT_IMPL(a_date_range, m_axis_tvalid, (s6_month_reg >= 4'd1) && (s6_month_reg <= 4'd12) && (s6_day_reg >= 5'd1), "month or day out of range")
    `TTC_ASSERT_IMPL(a_time_range, m_axis_tvalid, (s6_hour_reg < 5'd24) && (s6_minute_reg < 6'd60) && (s6_second_reg < 6'd60), "time of day out of range")

endmodule

// File: tb/ttc_calendar_checker.sv
// ----------------------------------------------------------------------------
// Timestamp to calendar checker
// Watches both stream channels, predicts each calendar date and compares.
// ----------------------------------------------------------------------------
module ttc_calendar_checker
    import ttc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [30:0] seconds_since_epoch, [31] zero
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [39:0] m_axis_tdata,   // [10:0] cal_year, [14:11] cal_month,
                                        // [19:15] cal_day, [24:20] cal_hour,
                                        // [30:25] cal_minute, [36:31] cal_second,
                                        // [39:37] zero
    output int          mismatches,
    output int          dates_pending
);

    // Packed so that year lands in the lowest bits, as on m_axis_tdata
    typedef struct packed {
        logic [SECOND_W-1:0] second;
        logic [MINUTE_W-1:0] minute;
        logic [HOUR_W-1:0]   hour;
        logic [DAY_W-1:0]    day;
        logic [MONTH_W-1:0]  month;
        logic [YEAR_W-1:0]   year;
    } cal_date_t;

    cal_date_t dates_due [$];
    cal_date_t want;
    cal_date_t got;

    function automatic int unsigned days_in_month(input int unsigned yr,
                                                  input int unsigned mo);
        case (mo)
            4, 6, 9, 11: return 30;
            2:           return (yr % 4 == 0) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    // Walk whole years, then whole months, then split the second of day
    function automatic cal_date_t to_calendar(input logic [TS_W-1:0] stamp);
        int unsigned days;
        int unsigned sod;
        int unsigned yr;
        int unsigned mo;
        int unsigned hh;
        cal_date_t   d;
        days = stamp / 86400;
        sod  = stamp % 86400;
        yr   = 1970;
        mo   = 1;
        while (days >= ((yr % 4 == 0) ? 366 : 365))
        begin
            days = days - ((yr % 4 == 0) ? 366 : 365);
            yr   = yr + 1;
        end
        // December takes whatever is left, so a leap year's last day stays in it
        while (mo < 12 && days >= days_in_month(yr, mo))
        begin
            days = days - days_in_month(yr, mo);
            mo   = mo + 1;
        end
        hh       = sod / 3600;
        sod      = sod - hh * 3600;
        d.year   = YEAR_W'(yr);
        d.month  = MONTH_W'(mo);
        d.day    = DAY_W'(days + 1);
        d.hour   = HOUR_W'(hh);
        d.minute = MINUTE_W'(sod / 60);
        d.second = SECOND_W'(sod % 60);
        return d;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dates_due.delete();
            mismatches    = 0;
            dates_pending = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                dates_due.push_back(to_calendar(s_axis_tdata[TS_W-1:0]));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[$bits(cal_date_t)-1:0];
                if (dates_due.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("unexpected date %0d-%0d-%0d %0d:%0d:%0d",
                                 got.year, got.month, got.day,
                                 got.hour, got.minute, got.second);
                    end
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = dates_due.pop_front();
                    if (got !== want)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("date mismatch: expected %0d-%0d-%0d %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d",
                                     want.year, want.month, want.day,
                                     want.hour, want.minute, want.second,
                                     got.year, got.month, got.day,
                                     got.hour, got.minute, got.second);
                        end
                        mismatches = mismatches + 1;
                    end
                end
            end
            dates_pending = dates_due.size();
        end
    end

endmodule

// File: tb/timestamp_to_calendar_core_tb.sv
// ----------------------------------------------------------------------------
// Timestamp to calendar core testbench
// Streams epoch timestamps through the core and checks every calendar date.
// ----------------------------------------------------------------------------
// The stimulus opens with corner timestamps (epoch, range end, month and year
// boundaries, the last day of leap years, the padding bit set) and then
// streams random words: uniform stamps, random dates and stamps next to
// midnight at month ends. Both sides idle at random. Along the way the sink
// holds off long enough to back the pipe up into the input, the source waits
// for a full drain, and a stretch runs with no idling at all. The checker
// beside the core predicts each date and counts mismatches.
// ----------------------------------------------------------------------------
module timestamp_to_calendar_core_tb;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata  = '0;     // [30:0] seconds_since_epoch, [31] zero
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;           // [10:0] cal_year, [14:11] cal_month,
                                         // [19:15] cal_day, [24:20] cal_hour,
                                         // [30:25] cal_minute, [36:31] cal_second,
                                         // [39:37] zero
    int          mismatches;
    int          dates_pending;
    int          cycle_count   = 0;
    bit          hold_req      = 1'b0;   // ask the sink for one long hold-off
    bit          calm          = 1'b0;   // no idling on either side

    always #5 clk = ~clk;

    timestamp_to_calendar_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ttc_calendar_checker calendar_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .mismatches    (mismatches),
        .dates_pending (dates_pending)
    );

    // Mostly back to back, often a short gap, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic int month_len(input int yr, input int mo);
        case (mo)
            4, 6, 9, 11: return 30;
            2:           return (yr % 4 == 0) ? 29 : 28;
            default:     return 31;
        endcase
    endfunction

    // Seconds since the epoch of a calendar date and time
    function automatic logic [31:0] epoch_seconds(input int yr, input int mo, input int dy,
                                                  input int hh, input int mm, input int ss);
        int unsigned total;
        total = 0;
        for (int y = 1970; y < yr; y++)
        begin
            total = total + ((y % 4 == 0) ? 366 : 365);
        end
        for (int m = 1; m < mo; m++)
        begin
            total = total + month_len(yr, m);
        end
        total = (total + dy - 1) * 86400 + hh * 3600 + mm * 60 + ss;
        return total;
    endfunction

    // Mix uniform stamps, random dates and stamps right at a month change
    function automatic logic [31:0] random_stamp();
        int pick;
        int yr;
        int mo;
        int dy;
        pick = $urandom_range(0, 99);
        yr   = $urandom_range(1970, 2037);
        mo   = $urandom_range(1, 12);
        dy   = $urandom_range(1, month_len(yr, mo));
        if (pick < 35)
        begin
            return {1'b0, 31'($urandom)};
        end
        if (pick < 80)
        begin
            return epoch_seconds(yr, mo, dy, $urandom_range(0, 23),
                                 $urandom_range(0, 59), $urandom_range(0, 59));
        end
        if (pick < 90)
        begin
            return epoch_seconds(yr, mo, month_len(yr, mo), 23, 59, $urandom_range(50, 59));
        end
        return epoch_seconds(yr, mo, 1, 0, 0, $urandom_range(0, 9));
    endfunction

    // Offer one word after a gap of idle cycles and hold it until accepted
    task automatic send_word(input logic [31:0] w, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
    endtask

    // Sink: random stalls, one long hold-off on request, none while calm
    initial
    begin : sink
        int  stall_left;
        bit  hold_taken;
        stall_left = 0;
        hold_taken = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (calm)
            begin
                m_axis_tready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left = stall_left - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 99) < 25)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    // Hard stop if the run hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL timestamp_to_calendar_core");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [31:0] corner_words [$];
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Corners: epoch, unit rollovers, month and year ends, leap days
        corner_words.push_back(32'd0);
        corner_words.push_back(32'd59);
        corner_words.push_back(32'd3599);
        corner_words.push_back(32'd86399);
        corner_words.push_back(32'd86400);
        corner_words.push_back(epoch_seconds(1970, 1, 31, 23, 59, 59));
        corner_words.push_back(epoch_seconds(1970, 2, 28, 23, 59, 59));
        corner_words.push_back(epoch_seconds(1970, 12, 31, 23, 59, 59));
        corner_words.push_back(epoch_seconds(1971, 1, 1, 0, 0, 0));
        corner_words.push_back(epoch_seconds(1972, 2, 28, 23, 59, 59));
        corner_words.push_back(epoch_seconds(1972, 2, 29, 12, 30, 30));
        corner_words.push_back(epoch_seconds(1972, 3, 1, 0, 0, 0));
        // Last day of a leap year must stay in December of that year
        corner_words.push_back(epoch_seconds(1972, 12, 31, 0, 0, 0));
        corner_words.push_back(epoch_seconds(1972, 12, 31, 23, 59, 59));
        corner_words.push_back(epoch_seconds(1973, 1, 1, 0, 0, 0));
        corner_words.push_back(epoch_seconds(2000, 2, 29, 23, 59, 59));
        corner_words.push_back(epoch_seconds(2036, 12, 31, 23, 59, 59));
        corner_words.push_back(epoch_seconds(2037, 12, 31, 23, 59, 59));
        corner_words.push_back(epoch_seconds(2038, 1, 1, 0, 0, 0));
        corner_words.push_back(32'h4000_0000);
        corner_words.push_back(32'h7FFF_FFFE);
        corner_words.push_back(32'h7FFF_FFFF);
        // Padding bit set: only the low 31 bits count
        corner_words.push_back(32'hFFFF_FFFF);
        corner_words.push_back(32'h8000_0000);
        foreach (corner_words[i])
        begin
            send_word(corner_words[i], pick_gap());
        end

        repeat (800) send_word(random_stamp(), pick_gap());

        // Back up the pipe: sink holds off while words keep coming
        hold_req = 1'b1;
        repeat (60) send_word(random_stamp(), 0);

        // Drop valid and wait for a full drain
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (dates_pending != 0) @(negedge clk);

        // Full rate on both sides
        calm = 1'b1;
        repeat (200) send_word(random_stamp(), 0);
        calm = 1'b0;

        repeat (700) send_word(random_stamp(), pick_gap());

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (dates_pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("PASS timestamp_to_calendar_core");
        end
        else
        begin
            $display("FAIL timestamp_to_calendar_core");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/ttc_pkg.sv
rtl/ttc_month_find.sv
rtl/timestamp_to_calendar_core.sv
tb/ttc_calendar_checker.sv
tb/timestamp_to_calendar_core_tb.sv
